>>> src/llba_pkg.sv
// Package for the least-loaded bin assigner.
// Holds default sizes and fixed field widths; no dependencies.
`default_nettype none
package llba_pkg;

  // default sizes
  localparam int MAX_BINS_DEF   = 128;
  localparam int COUNT_BITS_DEF = 16;

  // fixed field widths
  localparam int BIN_W = 8;

  // reset value of the bins-in-use register
  localparam logic [BIN_W-1:0] BINS_RESET = 8'd128;

endpackage
`default_nettype wire

>>> src/llba_cell.sv
// One bin cell: holds a bin's occupancy counter and takes part in the
// running-minimum search that flows along the row. Depends on llba_pkg.
`default_nettype none
module llba_cell
  import llba_pkg::*;
#(
  parameter int MAX_BINS   = MAX_BINS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int CELL_IDX   = 0,
  localparam int IDX_W = $clog2(MAX_BINS),
  localparam int CNT_W = $clog2(MAX_BINS + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [CNT_W-1:0]      n_bins,
  input  wire logic                  chg_en,
  input  wire logic [IDX_W-1:0]      chg_idx,
  input  wire logic                  in_vld,
  input  wire logic                  in_have,
  input  wire logic [COUNT_BITS-1:0] in_cnt,
  input  wire logic [IDX_W-1:0]      in_idx,
  output logic                       out_vld,
  output logic                       out_have,
  output logic [COUNT_BITS-1:0]      out_cnt,
  output logic [IDX_W-1:0]           out_idx
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [COUNT_BITS-1:0] cnt;
  logic                  active;
  logic                  take;

  assign active = (CNT_W'(CELL_IDX) < n_bins);
  // strict less keeps the lowest index on ties
  assign take   = active && (!in_have || (cnt < in_cnt));

  // occupancy counter, saturating
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (chg_en && (chg_idx == MY_IDX) && !(&cnt)) begin
      cnt <= cnt + 1'b1;
    end
  end

  // search token stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_have <= 1'b1;
      out_cnt  <= cnt;
      out_idx  <= MY_IDX;
    end else begin
      out_have <= in_have;
      out_cnt  <= in_cnt;
      out_idx  <= in_idx;
    end
  end

endmodule
`default_nettype wire

>>> src/least_loaded_bin_assigner_core.sv
// Least-loaded bin assigner, top level. Depends on llba_pkg and llba_cell.
// Automatic placement: the search token walks the cell row, one cell per cycle,
//   then the pick and the output register are loaded; a named bin skips the search.
// A new request is taken only in idle, after the previous result has been loaded into
//   the output register; that load waits while a held result is stalled by out_stall.
// Reset: synchronous; all counters cleared, bins_in_use returns to 128.
`default_nettype none
module least_loaded_bin_assigner_core
  import llba_pkg::*;
#(
  parameter int MAX_BINS   = MAX_BINS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [BIN_W-1:0] requested_bin,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [BIN_W-1:0]      chosen_bin,
  output logic                  request_error,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [BIN_W-1:0] bins_in_use
);

  localparam int IDX_W = $clog2(MAX_BINS);
  localparam int CNT_W = $clog2(MAX_BINS + 1);
  localparam int NW    = (CNT_W > BIN_W) ? CNT_W : BIN_W;
  localparam int PW    = ((IDX_W + 1) > BIN_W) ? (IDX_W + 1) : BIN_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]       state, state_next;
  logic [BIN_W-1:0] bins_cfg;
  logic [CNT_W-1:0] n_bins;
  logic [NW-1:0]    cfg_ext, req_ext, req_dec;
  logic [IDX_W-1:0] pick;
  logic             err_q;
  logic             in_acc, start, load, chg_en;
  logic [PW-1:0]    pick_one;

  // token chain wires, entry 0 feeds cell 0
  logic                  tok_vld  [0:MAX_BINS];
  logic                  tok_have [0:MAX_BINS];
  logic [COUNT_BITS-1:0] tok_cnt  [0:MAX_BINS];
  logic [IDX_W-1:0]      tok_idx  [0:MAX_BINS];
  logic [MAX_BINS-1:0]   vld_vec;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      bins_cfg <= BINS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      bins_cfg <= bins_in_use;
    end
  end

  // active bin count: zero means one, clamp at MAX_BINS
  assign cfg_ext = NW'(bins_cfg);
  always_comb begin
    if (bins_cfg == '0) begin
      n_bins = CNT_W'(1);
    end else if (cfg_ext > NW'(MAX_BINS)) begin
      n_bins = CNT_W'(MAX_BINS);
    end else begin
      n_bins = cfg_ext[CNT_W-1:0];
    end
  end

  // request decode
  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign req_ext  = NW'(requested_bin);
  assign req_dec  = req_ext - NW'(1);
  assign start    = in_acc && (requested_bin == '0);
  assign load     = (state == ST_FINISH) && (!out_valid || !out_stall);
  assign chg_en   = load && !err_q;

  // control
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          state_next = (requested_bin == '0) ? ST_SEARCH : ST_FINISH;
        end
      end
      ST_SEARCH: begin
        if (tok_vld[MAX_BINS]) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // chosen bin and error flag of the current request
  always_ff @(posedge clk) begin
    if (in_acc) begin
      err_q <= (requested_bin != '0) && (req_ext > NW'(n_bins));
      pick  <= req_dec[IDX_W-1:0];
    end else if ((state == ST_SEARCH) && tok_vld[MAX_BINS]) begin
      err_q <= 1'b0;
      pick  <= tok_idx[MAX_BINS];
    end
  end

  // output register
  assign pick_one = PW'(pick) + PW'(1);
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      chosen_bin    <= err_q ? '0 : pick_one[BIN_W-1:0];
      request_error <= err_q;
    end
  end

  // cell row
  assign tok_vld[0]  = start;
  assign tok_have[0] = 1'b0;
  assign tok_cnt[0]  = '0;
  assign tok_idx[0]  = '0;

  for (genvar i = 0; i < MAX_BINS; i++) begin : g_cell
    llba_cell #(
      .MAX_BINS  (MAX_BINS),
      .COUNT_BITS(COUNT_BITS),
      .CELL_IDX  (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .n_bins  (n_bins),
      .chg_en  (chg_en),
      .chg_idx (pick),
      .in_vld  (tok_vld[i]),
      .in_have (tok_have[i]),
      .in_cnt  (tok_cnt[i]),
      .in_idx  (tok_idx[i]),
      .out_vld (tok_vld[i+1]),
      .out_have(tok_have[i+1]),
      .out_cnt (tok_cnt[i+1]),
      .out_idx (tok_idx[i+1])
    );
    assign vld_vec[i] = tok_vld[i+1];
  end

  // checks
  a_one_token: assert property (@(posedge clk) disable iff (rst) $onehot0(vld_vec))
    else $error("more than one search token in the cell row");
  a_token_in_search: assert property (@(posedge clk) disable iff (rst)
    tok_vld[MAX_BINS] |-> (state == ST_SEARCH))
    else $error("search token left the row outside a search");
  a_err_zero_bin: assert property (@(posedge clk) disable iff (rst)
    (out_valid && request_error) |-> (chosen_bin == '0))
    else $error("refused request carries a bin number");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    load |=> (state == ST_IDLE) && out_valid)
    else $error("result load did not return to idle");

endmodule
`default_nettype wire

>>> test/tb_least_loaded_bin_assigner_core.sv
// Self-checking testbench for least_loaded_bin_assigner_core (uses llba_pkg).
// Directed table, a skewed-load run and random phases at several bin counts,
// checked against typed results from the table or an in-bench placement predictor.
`timescale 1ns / 100ps
module tb_least_loaded_bin_assigner_core
  import llba_pkg::*;
();

  localparam int MAX_BINS    = MAX_BINS_DEF;
  localparam int COUNT_BITS  = COUNT_BITS_DEF;
  localparam int HOLD_CYCLES = 400;
  localparam int STUCK_LIMIT = 3000;
  localparam int PHASE_ITEMS = 100;
  localparam int SKEW_ITEMS  = 20;

  localparam logic [BIN_W-1:0]      AUTO_PLACE = '0;
  localparam logic [BIN_W-1:0]      NO_BIN     = '0;
  localparam logic                  ACCEPTED   = 1'b0;
  localparam logic                  REFUSED    = 1'b1;
  localparam logic [COUNT_BITS-1:0] LOAD_MAX   = '1;

  typedef struct packed {
    logic [BIN_W-1:0] bin;
    logic             err;
  } placement_t;

  typedef enum logic {ROW_CONFIG, ROW_REQUEST} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [BIN_W-1:0] value;
    bit               typed;
    placement_t       want;
  } plan_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [BIN_W-1:0] requested_bin = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [BIN_W-1:0] chosen_bin;
  logic             request_error;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [BIN_W-1:0] bins_in_use = BINS_RESET;

  // predictor state
  logic [COUNT_BITS-1:0] bin_load [MAX_BINS];
  logic [BIN_W-1:0]      bins_reg;
  placement_t            pending_placements[$];
  plan_row_t             plan[$];

  int mismatches = 0;
  int stuck_cycles = 0;
  bit calm = 1'b0;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;
  placement_t oldest;

  least_loaded_bin_assigner_core #(
    .MAX_BINS  (MAX_BINS),
    .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .requested_bin(requested_bin),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .chosen_bin   (chosen_bin),
    .request_error(request_error),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .bins_in_use  (bins_in_use)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // number of bins searched for the current register value
  function automatic int active_span();
    if (bins_reg == 0) return 1;
    if (bins_reg > MAX_BINS) return MAX_BINS;
    return bins_reg;
  endfunction

  // work out the placement of one request and charge the predictor's counter
  task automatic place_request(input logic [BIN_W-1:0] req, output placement_t res);
    int span;
    int pick;
    int i;
    span = active_span();
    if (req != AUTO_PLACE && req > span) begin
      res.bin = NO_BIN;
      res.err = REFUSED;
    end else begin
      if (req == AUTO_PLACE) begin
        pick = 0;
        for (i = 1; i < span; i++)
          if (bin_load[i] < bin_load[pick]) pick = i;
      end else begin
        pick = req - 1;
      end
      if (bin_load[pick] != LOAD_MAX) bin_load[pick] = bin_load[pick] + 1'b1;
      res.bin = BIN_W'(pick + 1);
      res.err = ACCEPTED;
    end
  endtask

  // offer one request, hold it until taken, then queue what it should produce
  task automatic issue_request(input logic [BIN_W-1:0] req, input bit typed,
                               input placement_t typed_res);
    placement_t res;
    while (!calm && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    requested_bin <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    place_request(req, res);
    pending_placements.push_back(typed ? typed_res : res);
  endtask

  // register write, only once every pending result has come back
  task automatic set_bins_in_use(input logic [BIN_W-1:0] value);
    in_valid <= 1'b0;
    while (pending_placements.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    bins_in_use <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    bins_reg = value;
  endtask

  function automatic void add_row(row_kind_t kind, logic [BIN_W-1:0] value, bit typed,
                                  logic [BIN_W-1:0] bin, logic err);
    plan_row_t row;
    row.kind     = kind;
    row.value    = value;
    row.typed    = typed;
    row.want.bin = bin;
    row.want.err = err;
    plan.push_back(row);
  endfunction

  function automatic logic [BIN_W-1:0] random_request();
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) return AUTO_PLACE;
    if (pick < 85) return BIN_W'($urandom_range(active_span(), 1));
    return BIN_W'($urandom_range(255));
  endfunction

  // receiver: random stalls, long hold-off on request, none while calm
  always @(posedge clk) begin
    if (hold_asked != hold_served) begin
      hold_served <= hold_asked;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 31);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_placements.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result: expected none, got chosen_bin %0d request_error %0d",
                 $time, chosen_bin, request_error);
      end else begin
        oldest = pending_placements.pop_front();
        if (chosen_bin !== oldest.bin) begin
          mismatches++;
          $display("%0t chosen_bin expected %0d got %0d", $time, oldest.bin, chosen_bin);
        end
        if (request_error !== oldest.err) begin
          mismatches++;
          $display("%0t request_error expected %0d got %0d",
                   $time, oldest.err, request_error);
        end
      end
    end
  end

  // watchdog: too long without any handshake on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("FAIL least_loaded_bin_assigner_core");
      $finish;
    end
  end

  initial begin
    logic [BIN_W-1:0] cfg_choice [9];
    int row;
    int phase;
    int n;

    foreach (bin_load[i]) bin_load[i] = '0;
    bins_reg = BINS_RESET;

    // directed plan; typed results only where obvious
    add_row(ROW_REQUEST, AUTO_PLACE, 1, 8'd1,   ACCEPTED); // all empty: lowest bin
    add_row(ROW_REQUEST, AUTO_PLACE, 1, 8'd2,   ACCEPTED);
    add_row(ROW_REQUEST, 8'd128,     1, 8'd128, ACCEPTED); // top bin by name
    add_row(ROW_REQUEST, 8'd129,     1, NO_BIN, REFUSED);
    add_row(ROW_REQUEST, 8'd255,     1, NO_BIN, REFUSED);
    add_row(ROW_REQUEST, 8'd1,       1, 8'd1,   ACCEPTED);
    add_row(ROW_REQUEST, AUTO_PLACE, 0, NO_BIN, ACCEPTED);
    add_row(ROW_CONFIG,  8'd0,       0, NO_BIN, ACCEPTED); // zero acts as one bin
    add_row(ROW_REQUEST, AUTO_PLACE, 1, 8'd1,   ACCEPTED);
    add_row(ROW_REQUEST, 8'd2,       1, NO_BIN, REFUSED);
    add_row(ROW_REQUEST, 8'd1,       1, 8'd1,   ACCEPTED);
    add_row(ROW_CONFIG,  8'd255,     0, NO_BIN, ACCEPTED); // clamps to MAX_BINS
    add_row(ROW_REQUEST, 8'd128,     1, 8'd128, ACCEPTED);
    add_row(ROW_REQUEST, AUTO_PLACE, 0, NO_BIN, ACCEPTED);
    add_row(ROW_CONFIG,  8'd2,       0, NO_BIN, ACCEPTED);
    add_row(ROW_REQUEST, AUTO_PLACE, 0, NO_BIN, ACCEPTED);
    add_row(ROW_REQUEST, 8'd3,       1, NO_BIN, REFUSED);
    add_row(ROW_REQUEST, 8'd2,       1, 8'd2,   ACCEPTED);
    add_row(ROW_CONFIG,  8'd1,       0, NO_BIN, ACCEPTED);
    add_row(ROW_REQUEST, 8'd170,     1, NO_BIN, REFUSED);
    add_row(ROW_REQUEST, 8'd85,      1, NO_BIN, REFUSED);
    add_row(ROW_REQUEST, AUTO_PLACE, 1, 8'd1,   ACCEPTED);
    add_row(ROW_CONFIG,  8'd129,     0, NO_BIN, ACCEPTED);
    add_row(ROW_REQUEST, AUTO_PLACE, 0, NO_BIN, ACCEPTED);
    add_row(ROW_CONFIG,  8'd128,     0, NO_BIN, ACCEPTED);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (row = 0; row < plan.size(); row++) begin
      if (plan[row].kind == ROW_CONFIG)
        set_bins_in_use(plan[row].value);
      else
        issue_request(plan[row].value, plan[row].typed, plan[row].want);
    end

    // load one bin by name, then let automatic placement run around it
    calm <= 1'b1;
    for (n = 0; n < SKEW_ITEMS; n++)
      issue_request(8'd64, 0, '0);
    for (n = 0; n < 6; n++)
      issue_request(AUTO_PLACE, 0, '0);
    calm <= 1'b0;

    // random phases at several bin counts
    cfg_choice[0] = 8'd2;
    cfg_choice[1] = 8'd0;
    cfg_choice[2] = 8'd128;
    cfg_choice[3] = 8'd255;
    cfg_choice[4] = 8'd1;
    cfg_choice[5] = BIN_W'($urandom_range(MAX_BINS, 1));
    cfg_choice[6] = BIN_W'($urandom_range(255));
    cfg_choice[7] = 8'd7;
    cfg_choice[8] = 8'd128;
    for (phase = 0; phase < 9; phase++) begin
      set_bins_in_use(cfg_choice[phase]);
      if (phase == 2) hold_asked <= hold_asked + 1; // receiver backs up the block
      calm <= (phase == 3);
      for (n = 0; n < PHASE_ITEMS; n++)
        issue_request(random_request(), 0, '0);
    end
    calm <= 1'b0;
    in_valid <= 1'b0;

    // drain, then watch for stray results
    while (pending_placements.size() != 0) @(posedge clk);
    repeat (MAX_BINS + 10) @(posedge clk);
    if (mismatches == 0)
      $display("PASS least_loaded_bin_assigner_core");
    else
      $display("FAIL least_loaded_bin_assigner_core");
    $finish;
  end

endmodule
